>>> rtl/core/integer_to_ascii_formatter_defines.svh
// Assertion macros shared by the checker of the integer to ASCII formatter.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Assertion sampled on the rising clock and switched off while reset is high.
`define ITOA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock that also holds across reset.
`define ITOA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/itoa_pkg.sv
// Package of the integer to ASCII formatter: payload types, mode codes,
// character constants, sequencer states and the digit to ASCII function.
// Depends on nothing.
package itoa_pkg;

   localparam logic [2:0] MODE_HEX4  = 3'd0;
   localparam logic [2:0] MODE_HEX8  = 3'd1;
   localparam logic [2:0] MODE_HEX16 = 3'd2;
   localparam logic [2:0] MODE_HEX32 = 3'd3;
   localparam logic [2:0] MODE_UDEC  = 3'd4;
   localparam logic [2:0] MODE_SDEC  = 3'd5;

   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
   localparam logic [7:0] CHAR_HEX_BASE = 8'h37;
   localparam logic [7:0] CHAR_MINUS    = 8'h2d;

   localparam int DEC_DIGITS = 10;
   localparam int VALUE_BITS = 32;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   function automatic logic [7:0] digit_to_ascii(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'h0, nibble};
      if (nibble > 4'd9) begin
         return wide + CHAR_HEX_BASE;
      end
      return wide + CHAR_ZERO;
   endfunction

endpackage

>>> rtl/core/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: top level with sequencer and output register.
// Depends on itoa_pkg and itoa_dabble_unit.
//
// Usage: a request on req_ carries a mode and a 32-bit value. Modes 0 to 3
// print the low 4, 8, 16 or 32 bits as fixed-length upper-case hex; mode 4
// prints unsigned decimal without leading zeros; mode 5 prints signed decimal
// with a leading minus when negative. Modes 6 and 7 are taken and dropped.
// Characters leave on rsp_ most significant first, one per handshake, with
// last set on the final character of each request.
// req_ready is high only while the sequencer is idle, so a new request is
// taken only once the last has passed its final character to the output
// register. A hex request goes straight to the emit state; a decimal request
// first passes through the shared shift-and-add-3 unit (one value bit per
// cycle), then drops leading zeros one at a time. Characters then go out at
// one character per cycle while the receiver keeps up.
// The final character sits in the output register while the next request is
// taken. When the receiver stalls, rsp_payload holds and the emit state waits.
// Reset is synchronous and active high; it returns the sequencer to idle and
// clears the output valid.
module integer_to_ascii_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itoa_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itoa_pkg::rsp_type rsp_payload
);

   localparam int DigitBits = itoa_pkg::DEC_DIGITS * 4;

   itoa_pkg::state_type state_ff, state_in;
   logic [DigitBits-1:0]            digits_ff, digits_in;
   logic [itoa_pkg::VALUE_BITS-1:0] bin_ff, bin_in;
   logic [4:0]                      iter_ff, iter_in;
   logic [3:0]                      remain_ff, remain_in;
   logic                            sign_ff, sign_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   itoa_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [DigitBits-1:0]            dab_digits;
   logic [itoa_pkg::VALUE_BITS-1:0] dab_bin;
   logic                            out_free;

   // Conversion unit shared by both decimal modes: one binary bit enters the BCD digits per cycle.
   itoa_dabble_unit u_dabble (
      .digits_i (digits_ff),
      .bin_i    (bin_ff),
      .digits_o (dab_digits),
      .bin_o    (dab_bin)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == itoa_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      bin_in       = bin_ff;
      iter_in      = iter_ff;
      remain_in    = remain_ff;
      sign_in      = sign_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         itoa_pkg::ST_IDLE: begin
            if (req_valid) begin
               sign_in = 1'b0;
               iter_in = '0;
               // Hex digits are placed at the top of the digit register, so the
               // emitter always takes the top nibble first.
               case (req_payload.mode)
                  itoa_pkg::MODE_HEX4: begin
                     digits_in = {req_payload.value[3:0], 36'h0};
                     remain_in = 4'd1;
                     state_in  = itoa_pkg::ST_EMIT;
                  end
                  itoa_pkg::MODE_HEX8: begin
                     digits_in = {req_payload.value[7:0], 32'h0};
                     remain_in = 4'd2;
                     state_in  = itoa_pkg::ST_EMIT;
                  end
                  itoa_pkg::MODE_HEX16: begin
                     digits_in = {req_payload.value[15:0], 24'h0};
                     remain_in = 4'd4;
                     state_in  = itoa_pkg::ST_EMIT;
                  end
                  itoa_pkg::MODE_HEX32: begin
                     digits_in = {req_payload.value, 8'h0};
                     remain_in = 4'd8;
                     state_in  = itoa_pkg::ST_EMIT;
                  end
                  itoa_pkg::MODE_UDEC: begin
                     digits_in = '0;
                     bin_in    = req_payload.value;
                     state_in  = itoa_pkg::ST_CONVERT;
                  end
                  itoa_pkg::MODE_SDEC: begin
                     digits_in = '0;
                     sign_in   = req_payload.value[31];
                     // The negation wraps, so the most negative value keeps its pattern
                     // and still reads as the right unsigned magnitude.
                     if (req_payload.value[31]) begin
                        bin_in = ~req_payload.value + 32'd1;
                     end else begin
                        bin_in = req_payload.value;
                     end
                     state_in = itoa_pkg::ST_CONVERT;
                  end
                  default: begin
                     state_in = itoa_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         itoa_pkg::ST_CONVERT: begin
            digits_in = dab_digits;
            bin_in    = dab_bin;
            iter_in   = iter_ff + 5'd1;
            if (iter_ff == 5'd31) begin
               remain_in = 4'(itoa_pkg::DEC_DIGITS);
               state_in  = itoa_pkg::ST_SKIP;
            end
         end

         itoa_pkg::ST_SKIP: begin
            // Leading zeros go one per cycle; the units digit always stays.
            if (digits_ff[DigitBits-1 -: 4] == 4'd0 && remain_ff > 4'd1) begin
               digits_in = {digits_ff[DigitBits-5:0], 4'h0};
               remain_in = remain_ff - 4'd1;
            end else begin
               state_in = itoa_pkg::ST_EMIT;
            end
         end

         itoa_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_data_in.character = itoa_pkg::CHAR_MINUS;
                  rsp_data_in.last      = 1'b0;
                  sign_in               = 1'b0;
               end else begin
                  rsp_data_in.character =
                     itoa_pkg::digit_to_ascii(digits_ff[DigitBits-1 -: 4]);
                  rsp_data_in.last      = (remain_ff == 4'd1);
                  digits_in             = {digits_ff[DigitBits-5:0], 4'h0};
                  remain_in             = remain_ff - 4'd1;
                  if (remain_ff == 4'd1) begin
                     state_in = itoa_pkg::ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = itoa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         iter_ff      <= '0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         iter_ff      <= iter_in;
         remain_ff    <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      bin_ff      <= bin_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/core/itoa_dabble_unit.sv
// One shift-and-add-3 step of binary to BCD conversion over ten digits.
// Depends on itoa_pkg for the digit count and value width.
module itoa_dabble_unit (
   input  logic [itoa_pkg::DEC_DIGITS*4-1:0] digits_i,
   input  logic [itoa_pkg::VALUE_BITS-1:0]   bin_i,
   output logic [itoa_pkg::DEC_DIGITS*4-1:0] digits_o,
   output logic [itoa_pkg::VALUE_BITS-1:0]   bin_o
);

   logic [itoa_pkg::DEC_DIGITS*4-1:0] adjusted;

   // Any digit of five or more is raised by three so that the shift carries into the next.
   always_comb begin
      for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++) begin
         if (digits_i[i*4 +: 4] >= 4'd5) begin
            adjusted[i*4 +: 4] = digits_i[i*4 +: 4] + 4'd3;
         end else begin
            adjusted[i*4 +: 4] = digits_i[i*4 +: 4];
         end
      end
   end

   assign digits_o = {adjusted[itoa_pkg::DEC_DIGITS*4-2:0], bin_i[itoa_pkg::VALUE_BITS-1]};
   assign bin_o    = {bin_i[itoa_pkg::VALUE_BITS-2:0], 1'b0};

endmodule

>>> rtl/core/itoa_checker.sv
// Port-level checker of the integer to ASCII formatter and its bind statement.
// Depends on itoa_pkg and integer_to_ascii_formatter_defines.svh.
`include "integer_to_ascii_formatter_defines.svh"

module itoa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input itoa_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input itoa_pkg::rsp_type rsp_payload
);

   `ITOA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid), "reset must leave the block idle with no character pending")

   `ITOA_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)), "stalled character changed or vanished")

   `ITOA_ASSERT(a_char_legal, clock, reset, rsp_valid |-> ((rsp_payload.character >= itoa_pkg::CHAR_ZERO && rsp_payload.character <= itoa_pkg::CHAR_NINE) || (rsp_payload.character >= itoa_pkg::CHAR_UPPER_A && rsp_payload.character <= itoa_pkg::CHAR_UPPER_F) || rsp_payload.character == itoa_pkg::CHAR_MINUS), "character is not a digit, A to F or minus")

   `ITOA_ASSERT(a_busy_after_req, clock, reset, (req_valid && req_ready && (req_payload.mode <= itoa_pkg::MODE_SDEC)) |=> !req_ready, "block took a printable request but stayed ready")

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);
